// ----- design/tsr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_pkg: shared types and constants of the TDMA slot reservation engine
// Field layout of the stream buses, header check values and table constants.
// ----------------------------------------------------------------------------
package tsr_pkg;

	// frame geometry
	localparam int unsigned SLOT_COUNT_DEF = 10;
	localparam int unsigned ID_W           = 8;
	localparam int unsigned ID_ENTRIES     = 9;
	localparam int unsigned RND_W          = 16;
	localparam int unsigned STEP_W         = 4;
	localparam int unsigned LISTEN_W       = 5;
	localparam int unsigned FRAME_CNT_W    = 16;
	localparam int unsigned OWN_SLOT_W     = 4;
	localparam int unsigned CMD_W          = 2;

	localparam logic [ID_W-1:0]     FREE_ID    = 8'hFF;
	localparam logic [ID_W-1:0]     HDR_LEN    = 8'd46;
	localparam logic [ID_W-1:0]     MAC_HDR    = 8'hE0;
	localparam logic [ID_W-1:0]     FRAME_CTRL = 8'h06;
	localparam logic [LISTEN_W-1:0] LISTEN_MAX = 5'd31;

	// command carried on the slave-side tuser
	typedef enum logic [CMD_W-1:0] {
		CMD_FRAME = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_RX    = 2'd2
	} cmd_t;

	// slave-side tdata layout
	localparam int unsigned IN_TDATA_W = 128;
	localparam int unsigned IN_FLEN    = 0;
	localparam int unsigned IN_MACH    = 8;
	localparam int unsigned IN_FCTL    = 16;
	localparam int unsigned IN_MIC     = 24;
	localparam int unsigned IN_IDS     = 25;  // nine slot IDs, then sender ID
	localparam int unsigned IN_SENDER  = 97;
	localparam int unsigned IN_RND     = 105;

	// master-side tdata layout
	localparam int unsigned OUT_TDATA_W = 112;
	localparam int unsigned OUT_TXNOW   = 0;
	localparam int unsigned OUT_FCNT    = 1;
	localparam int unsigned OUT_IDS     = 17;  // nine slot IDs, then own ID
	localparam int unsigned OUT_OWNID   = 89;
	localparam int unsigned OUT_OSLOT   = 97;
	localparam int unsigned OUT_OSV     = 101;
	localparam int unsigned OUT_COLL    = 102;
	localparam int unsigned OUT_ACQ     = 103;
	localparam int unsigned OUT_FAIL    = 104;

endpackage
`default_nettype wire

// ----- design/tdma_slot_reservation_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tdma_slot_reservation_top: distributed TDMA slot reservation engine
// Keeps the slot owner table, ages unheard slots, detects collisions and
// picks a free slot after a listen period; emits one header/decision per item.
// ----------------------------------------------------------------------------
// One transfer is taken on the slave side at a time and gives exactly one
// transfer on the master side. A command walks the slot table with a single
// sequencer, one table entry per cycle, and builds the outgoing header ID list
// one byte per cycle, nine bytes in all. A slot tick or frame pulse ages the
// previous slot and advances the listen count. When acquisition is due it
// also counts free slots and, if any is free, takes a bit-serial remainder
// of random_value by the free count and then locates the chosen slot. A
// received header first looks for the sender among heard owners when this
// node has transmitted in its held slot, then updates the table; a rejected
// header or an unused command only builds the outgoing header. The
// master-side output register lets the next transfer be taken while a result
// still waits.
module tdma_slot_reservation_top #(
	parameter int unsigned SLOT_COUNT = tsr_pkg::SLOT_COUNT_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output      logic                             cfg_ready,
	input  wire logic [tsr_pkg::ID_W-1:0]         cfg_data,    // own_node_id
	input  wire logic                             s_tvalid,
	output      logic                             s_tready,
	// frame_len, mac_header, frame_control, mic_match, neighbor_ids_low,
	// neighbor_ids_high, random_value, zero fill
	input  wire logic [tsr_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  wire logic [tsr_pkg::CMD_W-1:0]        s_tuser,     // cmd
	output      logic                             m_tvalid,
	input  wire logic                             m_tready,
	// transmit_now, tx_frame_count, tx_ids_low, tx_ids_high, own_slot,
	// own_slot_valid, collision_seen, slot_acquired, acquire_failed, zero fill
	output      logic [tsr_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	localparam int unsigned SW = $clog2(SLOT_COUNT);
	localparam int unsigned NW = $clog2(SLOT_COUNT + 1);
	localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);
	localparam logic [tsr_pkg::LISTEN_W-1:0] LISTEN_THR =
		tsr_pkg::LISTEN_W'(2 * SLOT_COUNT);
	localparam logic [tsr_pkg::STEP_W-1:0] LEARN_LAST = tsr_pkg::STEP_W'(SLOT_COUNT - 2);
	localparam logic [tsr_pkg::STEP_W-1:0] HDR_USED   = tsr_pkg::STEP_W'(SLOT_COUNT - 1);
	localparam logic [tsr_pkg::STEP_W-1:0] HDR_LAST   =
		tsr_pkg::STEP_W'(tsr_pkg::ID_ENTRIES - 1);
	localparam logic [tsr_pkg::STEP_W-1:0] DIV_LAST   = tsr_pkg::STEP_W'(tsr_pkg::RND_W - 1);

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b0000_0000_0001,
		ST_START = 12'b0000_0000_0010,
		ST_COUNT = 12'b0000_0000_0100,
		ST_DIV   = 12'b0000_0000_1000,
		ST_PICK  = 12'b0000_0001_0000,
		ST_TX    = 12'b0000_0010_0000,
		ST_RXCHK = 12'b0000_0100_0000,
		ST_RXUPD = 12'b0000_1000_0000,
		ST_RXCUR = 12'b0001_0000_0000,
		ST_LEARN = 12'b0010_0000_0000,
		ST_HINIT = 12'b0100_0000_0000,
		ST_HDR   = 12'b1000_0000_0000
	} state_t;

	// DONE folded into a flag: output load happens from its own state below
	typedef enum logic [1:0] {
		OUT_BUILD = 2'b01,
		OUT_LOAD  = 2'b10
	} out_phase_t;

	state_t                          state_q;
	out_phase_t                      phase_q;
	logic [tsr_pkg::ID_W-1:0]        owner_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0]           heard_q;
	logic [tsr_pkg::FRAME_CNT_W-1:0] frame_q;
	logic [SW-1:0]                   slot_q;
	logic [SW-1:0]                   held_q;
	logic                            held_vld_q;
	logic                            heard_now_q;
	logic                            sent_q;
	logic [tsr_pkg::LISTEN_W-1:0]    listen_q;
	logic [tsr_pkg::ID_W-1:0]        own_id_q;
	logic [SW-1:0]                   idx_q;
	logic [tsr_pkg::STEP_W-1:0]      step_q;
	logic [NW-1:0]                   nfree_q;
	logic [NW-1:0]                   rem_q;
	logic                            known_q;
	logic                            tx_now_q;
	logic                            coll_q;
	logic                            acq_q;
	logic                            fail_q;
	logic                            m_tvalid_q;

	// payload registers
	logic [tsr_pkg::RND_W-1:0]       rnd_q;
	logic [tsr_pkg::ID_W-1:0]        ids_q [tsr_pkg::ID_ENTRIES];
	logic [tsr_pkg::ID_W-1:0]        hdr_q [tsr_pkg::ID_ENTRIES];
	logic [tsr_pkg::ID_W-1:0]        sender_q;
	logic                            listed_q;
	logic [tsr_pkg::OUT_TDATA_W-1:0] m_tdata_q;

	logic [tsr_pkg::ID_W-1:0]        in_ids [tsr_pkg::ID_ENTRIES];
	logic                            in_hdr_ok;
	logic                            in_listed;
	logic [tsr_pkg::ID_W-1:0]        rd_owner;
	logic                            rd_heard;
	logic                            rd_free;
	logic [SW-1:0]                   idx_inc;
	logic [SW-1:0]                   slot_inc;
	logic [SW-1:0]                   prev_slot;
	logic [tsr_pkg::LISTEN_W-1:0]    listen_inc;
	logic [NW-1:0]                   nfree_nx;
	logic [NW:0]                     rem_sh;
	logic [NW-1:0]                   rem_nx;
	logic [tsr_pkg::ID_W-1:0]        hdr_byte;
	logic                            out_free;
	logic [tsr_pkg::OUT_TDATA_W-1:0] out_pack;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE) && (phase_q == OUT_BUILD);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign out_free  = !m_tvalid_q || m_tready;

	// unpack received header IDs and check header validity
	always_comb begin
		in_listed = 1'b0;
		for (int i = 0; i < tsr_pkg::ID_ENTRIES; i++) begin
			in_ids[i] = s_tdata[tsr_pkg::IN_IDS + tsr_pkg::ID_W*i +: tsr_pkg::ID_W];
		end
		for (int i = 0; i < SLOT_COUNT - 1; i++) begin
			if (in_ids[i] == own_id_q) begin
				in_listed = 1'b1;
			end
		end
		in_hdr_ok = (s_tdata[tsr_pkg::IN_FLEN +: tsr_pkg::ID_W] == tsr_pkg::HDR_LEN)
			&& (s_tdata[tsr_pkg::IN_MACH +: tsr_pkg::ID_W] == tsr_pkg::MAC_HDR)
			&& (s_tdata[tsr_pkg::IN_FCTL +: tsr_pkg::ID_W] == tsr_pkg::FRAME_CTRL)
			&& s_tdata[tsr_pkg::IN_MIC];
	end

	// table read port and walk arithmetic
	always_comb begin
		rd_owner   = owner_q[idx_q];
		rd_heard   = heard_q[idx_q];
		rd_free    = (rd_owner == tsr_pkg::FREE_ID);
		idx_inc    = (idx_q == LAST_SLOT) ? '0 : idx_q + 1'b1;
		slot_inc   = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
		prev_slot  = (slot_q == '0) ? LAST_SLOT : slot_q - 1'b1;
		listen_inc = (listen_q == tsr_pkg::LISTEN_MAX) ? listen_q : listen_q + 1'b1;
		nfree_nx   = nfree_q + NW'(rd_free);
		rem_sh     = {rem_q, rnd_q[tsr_pkg::RND_W-1]};
		rem_nx     = (rem_sh >= {1'b0, nfree_q}) ? NW'(rem_sh - {1'b0, nfree_q})
			: NW'(rem_sh);
		hdr_byte   = ((step_q < HDR_USED) && rd_heard) ? rd_owner : tsr_pkg::FREE_ID;
	end

	// pack the result transfer
	always_comb begin
		out_pack = '0;
		out_pack[tsr_pkg::OUT_TXNOW] = tx_now_q;
		out_pack[tsr_pkg::OUT_FCNT +: tsr_pkg::FRAME_CNT_W] = frame_q;
		for (int i = 0; i < tsr_pkg::ID_ENTRIES; i++) begin
			out_pack[tsr_pkg::OUT_IDS + tsr_pkg::ID_W*i +: tsr_pkg::ID_W] = hdr_q[i];
		end
		out_pack[tsr_pkg::OUT_OWNID +: tsr_pkg::ID_W] = own_id_q;
		out_pack[tsr_pkg::OUT_OSLOT +: tsr_pkg::OWN_SLOT_W] =
			held_vld_q ? tsr_pkg::OWN_SLOT_W'(held_q) : '0;
		out_pack[tsr_pkg::OUT_OSV]  = held_vld_q;
		out_pack[tsr_pkg::OUT_COLL] = coll_q;
		out_pack[tsr_pkg::OUT_ACQ]  = acq_q;
		out_pack[tsr_pkg::OUT_FAIL] = fail_q;
	end

	// sequencer and slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= OUT_BUILD;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				owner_q[i] <= tsr_pkg::FREE_ID;
			end
			heard_q     <= '0;
			frame_q     <= '0;
			slot_q      <= '0;
			held_q      <= '0;
			held_vld_q  <= 1'b0;
			heard_now_q <= 1'b0;
			sent_q      <= 1'b0;
			listen_q    <= '0;
			own_id_q    <= '0;
			idx_q       <= '0;
			step_q      <= '0;
			nfree_q     <= '0;
			rem_q       <= '0;
			known_q     <= 1'b0;
			tx_now_q    <= 1'b0;
			coll_q      <= 1'b0;
			acq_q       <= 1'b0;
			fail_q      <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				own_id_q <= cfg_data;
			end
			// drop a taken result unless a new one is loaded in its place
			if (m_tvalid_q && m_tready && (phase_q != OUT_LOAD)) begin
				m_tvalid_q <= 1'b0;
			end

			// hand the finished result to the output register
			if (phase_q == OUT_LOAD) begin
				if (out_free) begin
					m_tvalid_q <= 1'b1;
					phase_q    <= OUT_BUILD;
				end
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (s_tvalid) begin
							tx_now_q <= 1'b0;
							coll_q   <= 1'b0;
							acq_q    <= 1'b0;
							fail_q   <= 1'b0;
							known_q  <= 1'b0;
							idx_q    <= '0;
							case (tsr_pkg::cmd_t'(s_tuser))
								tsr_pkg::CMD_FRAME: begin
									frame_q <= frame_q + 1'b1;
									slot_q  <= '0;
									state_q <= ST_START;
								end
								tsr_pkg::CMD_TICK: begin
									slot_q  <= slot_inc;
									state_q <= ST_START;
								end
								tsr_pkg::CMD_RX: begin
									if (in_hdr_ok) begin
										heard_now_q <= 1'b1;
										state_q     <= sent_q ? ST_RXCHK : ST_RXUPD;
									end else begin
										state_q <= ST_HINIT;
									end
								end
								default: begin
									state_q <= ST_HINIT;
								end
							endcase
						end
					end
					// age the previous slot and advance the listen count
					ST_START: begin
						if (!heard_now_q) begin
							heard_q[prev_slot] <= 1'b0;
						end
						heard_now_q <= 1'b0;
						listen_q    <= listen_inc;
						idx_q       <= '0;
						nfree_q     <= '0;
						state_q     <= (listen_inc >= LISTEN_THR) ? ST_COUNT : ST_TX;
					end
					// count free slots
					ST_COUNT: begin
						nfree_q <= nfree_nx;
						idx_q   <= idx_inc;
						if (idx_q == LAST_SLOT) begin
							if (nfree_nx == '0) begin
								fail_q  <= 1'b1;
								state_q <= ST_TX;
							end else begin
								rem_q   <= '0;
								step_q  <= '0;
								state_q <= ST_DIV;
							end
						end
					end
					// one remainder bit per cycle
					ST_DIV: begin
						rem_q  <= rem_nx;
						step_q <= step_q + 1'b1;
						if (step_q == DIV_LAST) begin
							idx_q   <= '0;
							state_q <= ST_PICK;
						end
					end
					// locate the chosen free slot
					ST_PICK: begin
						idx_q <= idx_inc;
						if (idx_q == LAST_SLOT) begin
							state_q <= ST_TX;
						end
						if (rd_free) begin
							if (rem_q == '0) begin
								held_q     <= idx_q;
								held_vld_q <= 1'b1;
								listen_q   <= '0;
								sent_q     <= 1'b0;
								acq_q      <= 1'b1;
								state_q    <= ST_TX;
							end else begin
								rem_q <= rem_q - 1'b1;
							end
						end
					end
					ST_TX: begin
						if (held_vld_q && (slot_q == held_q)) begin
							tx_now_q <= 1'b1;
							sent_q   <= 1'b1;
						end
						state_q <= ST_HINIT;
					end
					// look for the sender among heard owners
					ST_RXCHK: begin
						if ((rd_owner == sender_q) && rd_heard) begin
							known_q <= 1'b1;
						end
						idx_q <= idx_inc;
						if (idx_q == LAST_SLOT) begin
							state_q <= ST_RXUPD;
						end
					end
					// drop the held slot on collision, else restart listening while one is held
					ST_RXUPD: begin
						if (sent_q && known_q && !listed_q) begin
							if (held_vld_q) begin
								owner_q[held_q] <= tsr_pkg::FREE_ID;
							end
							held_vld_q <= 1'b0;
							held_q     <= '0;
							sent_q     <= 1'b0;
							coll_q     <= 1'b1;
						end else if (held_vld_q) begin
							listen_q <= '0;
						end
						state_q <= ST_RXCUR;
					end
					ST_RXCUR: begin
						owner_q[slot_q] <= sender_q;
						heard_q[slot_q] <= 1'b1;
						idx_q           <= slot_inc;
						step_q          <= '0;
						state_q         <= ST_LEARN;
					end
					// learn owners of slots not heard directly
					ST_LEARN: begin
						if (!rd_heard && !(held_vld_q && (idx_q == held_q))) begin
							owner_q[idx_q] <= ids_q[0];
						end
						idx_q  <= idx_inc;
						step_q <= step_q + 1'b1;
						if (step_q == LEARN_LAST) begin
							state_q <= ST_HINIT;
						end
					end
					ST_HINIT: begin
						idx_q   <= slot_inc;
						step_q  <= '0;
						state_q <= ST_HDR;
					end
					// build the header ID list
					ST_HDR: begin
						idx_q  <= idx_inc;
						step_q <= step_q + 1'b1;
						if (step_q == HDR_LAST) begin
							phase_q <= OUT_LOAD;
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	// payload: captured fields, shift lines and the output register
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ids_q    <= in_ids;
			sender_q <= s_tdata[tsr_pkg::IN_SENDER +: tsr_pkg::ID_W];
			rnd_q    <= s_tdata[tsr_pkg::IN_RND +: tsr_pkg::RND_W];
			listed_q <= in_listed;
		end
		if ((phase_q == OUT_BUILD) && (state_q == ST_DIV)) begin
			rnd_q <= {rnd_q[tsr_pkg::RND_W-2:0], 1'b0};
		end
		if ((phase_q == OUT_BUILD) && (state_q == ST_LEARN)) begin
			for (int i = 0; i < tsr_pkg::ID_ENTRIES - 1; i++) begin
				ids_q[i] <= ids_q[i+1];
			end
			ids_q[tsr_pkg::ID_ENTRIES-1] <= tsr_pkg::FREE_ID;
		end
		if ((phase_q == OUT_BUILD) && (state_q == ST_HDR)) begin
			for (int i = 0; i < tsr_pkg::ID_ENTRIES - 1; i++) begin
				hdr_q[i] <= hdr_q[i+1];
			end
			hdr_q[tsr_pkg::ID_ENTRIES-1] <= hdr_byte;
		end
		if ((phase_q == OUT_LOAD) && out_free) begin
			m_tdata_q <= out_pack;
		end
	end

endmodule
`default_nettype wire

// ----- design/tsr_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_checker: port-level checks for the TDMA slot reservation engine
// Watches the stream ports and the result fields over time.
// ----------------------------------------------------------------------------
module tsr_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_tvalid,
	input wire logic                             s_tready,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [tsr_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	logic tx_now;
	logic osv;
	logic coll;
	logic acq;
	logic fail;
	logic [tsr_pkg::OWN_SLOT_W-1:0] oslot;

	assign tx_now = m_tdata[tsr_pkg::OUT_TXNOW];
	assign osv    = m_tdata[tsr_pkg::OUT_OSV];
	assign coll   = m_tdata[tsr_pkg::OUT_COLL];
	assign acq    = m_tdata[tsr_pkg::OUT_ACQ];
	assign fail   = m_tdata[tsr_pkg::OUT_FAIL];
	assign oslot  = m_tdata[tsr_pkg::OUT_OSLOT +: tsr_pkg::OWN_SLOT_W];

	// an accepted command keeps the engine busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("slave side ready right after a transfer");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// no held slot means slot index zero, and transmission needs a held slot
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !osv |-> oslot == '0 && !tx_now)
		else $error("slot fields inconsistent");

	// header events and slot-start events never share one result, and acquisition never both succeeds and fails
	a_event_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(coll && (acq || fail || tx_now)) && !(acq && fail))
		else $error("conflicting event flags");

endmodule

bind tdma_slot_reservation_top tsr_checker u_tsr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

// ----- test/tsr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsr_scoreboard: scoreboard for the TDMA slot reservation engine
// Watches the configuration and both stream channels and keeps its own copy of
// the slot table, counters and held slot. Each slave-side transfer yields one
// expected header/decision; each master-side transfer is compared field by
// field against the oldest expectation.
// ----------------------------------------------------------------------------
module tsr_scoreboard #(
	parameter int unsigned NSLOT = tsr_pkg::SLOT_COUNT_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	input  wire logic                             cfg_ready,
	input  wire logic [tsr_pkg::ID_W-1:0]         cfg_data,
	input  wire logic                             s_tvalid,
	input  wire logic                             s_tready,
	input  wire logic [tsr_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  wire logic [tsr_pkg::CMD_W-1:0]        s_tuser,
	input  wire logic                             m_tvalid,
	input  wire logic                             m_tready,
	input  wire logic [tsr_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output int                                    pending,
	output int                                    mismatches,
	output int                                    n_results,
	output int                                    n_acquired,
	output int                                    n_acq_failed,
	output int                                    n_collisions,
	output int                                    n_tx_slots
);
	import tsr_pkg::*;

	typedef struct {
		logic        txnow;
		logic [15:0] fcnt;
		logic [63:0] ids_lo;
		logic [15:0] ids_hi;
		logic [3:0]  oslot;
		logic        osv;
		logic        coll;
		logic        acq;
		logic        fail;
	} slot_result_t;

	slot_result_t decisions_q[$];
	slot_result_t want;
	slot_result_t got;

	// shadow of the engine state
	logic [ID_W-1:0]        owner_tbl [NSLOT];
	logic                   heard_tbl [NSLOT];
	logic [FRAME_CNT_W-1:0] frame_cnt;
	logic [STEP_W-1:0]      cur_slot;
	logic [OWN_SLOT_W-1:0]  my_slot;
	logic                   my_valid;
	logic                   rx_in_slot;
	logic                   tx_done;
	logic [LISTEN_W-1:0]    listen_cnt;
	logic [ID_W-1:0]        node_id;

	// Age the previous slot, advance listening, try to acquire, mark transmission.
	task automatic begin_slot(input logic [RND_W-1:0] rnd, inout slot_result_t r);
		int prev;
		int nfree;
		int pick;
		prev = (cur_slot == 0) ? NSLOT - 1 : int'(cur_slot) - 1;
		if (!rx_in_slot)
			heard_tbl[prev] = 1'b0;
		rx_in_slot = 1'b0;
		if (listen_cnt < LISTEN_MAX)
			listen_cnt = listen_cnt + 1'b1;
		if (listen_cnt >= 2 * NSLOT) begin
			nfree = 0;
			for (int i = 0; i < NSLOT; i++)
				if (owner_tbl[i] == FREE_ID)
					nfree++;
			if (nfree > 0) begin
				pick = int'(rnd) % nfree;
				for (int i = 0; i < NSLOT; i++) begin
					if (owner_tbl[i] == FREE_ID) begin
						if (pick == 0) begin
							my_slot = OWN_SLOT_W'(i);
							my_valid = 1'b1;
							listen_cnt = '0;
							tx_done = 1'b0;
							r.acq = 1'b1;
						end
						pick--;
					end
				end
			end else begin
				r.fail = 1'b1;
			end
		end
		if (my_valid && cur_slot == my_slot) begin
			r.txnow = 1'b1;
			tx_done = 1'b1;
		end
	endtask

	// Accept a well-formed header: collision check, then learn owners.
	task automatic take_header(input logic [IN_TDATA_W-1:0] d, inout slot_result_t r);
		logic [ID_W-1:0] ids [ID_ENTRIES];
		logic [ID_W-1:0] sender;
		int              s;
		bit              known;
		bit              listed;
		if (d[IN_FLEN +: 8] != HDR_LEN || d[IN_MACH +: 8] != MAC_HDR ||
				d[IN_FCTL +: 8] != FRAME_CTRL || !d[IN_MIC])
			return;
		for (int i = 0; i < ID_ENTRIES; i++)
			ids[i] = d[IN_IDS + 8*i +: 8];
		sender = d[IN_SENDER +: 8];
		rx_in_slot = 1'b1;
		known = 1'b0;
		listed = 1'b0;
		if (tx_done) begin
			for (int i = 0; i < NSLOT; i++)
				if (owner_tbl[i] == sender && heard_tbl[i])
					known = 1'b1;
			for (int i = 0; i < NSLOT - 1; i++)
				if (ids[i] == node_id)
					listed = 1'b1;
		end
		if (tx_done && known && !listed) begin
			if (my_valid)
				owner_tbl[my_slot] = FREE_ID;
			my_valid = 1'b0;
			my_slot = '0;
			tx_done = 1'b0;
			r.coll = 1'b1;
		end else if (my_valid) begin
			listen_cnt = '0;
		end
		owner_tbl[cur_slot] = sender;
		heard_tbl[cur_slot] = 1'b1;
		for (int i = 0; i < NSLOT - 1; i++) begin
			s = (int'(cur_slot) + 1 + i) % NSLOT;
			if (!heard_tbl[s] && !(my_valid && s == int'(my_slot)))
				owner_tbl[s] = ids[i];
		end
	endtask

	// Build the outgoing header and held-slot fields from the updated state.
	task automatic fill_header(inout slot_result_t r);
		logic [ID_W-1:0] hb [ID_ENTRIES];
		int              s;
		for (int i = 0; i < ID_ENTRIES; i++)
			hb[i] = FREE_ID;
		for (int i = 0; i < NSLOT - 1; i++) begin
			s = (int'(cur_slot) + 1 + i) % NSLOT;
			hb[i] = heard_tbl[s] ? owner_tbl[s] : FREE_ID;
		end
		for (int i = 0; i < 8; i++)
			r.ids_lo[8*i +: 8] = hb[i];
		r.ids_hi = {node_id, hb[8]};
		r.fcnt = frame_cnt;
		r.oslot = my_valid ? my_slot : '0;
		r.osv = my_valid;
	endtask

	task automatic predict_decision(input logic [CMD_W-1:0] c, input logic [IN_TDATA_W-1:0] d);
		slot_result_t r;
		r = '{default: '0};
		case (cmd_t'(c))
			CMD_FRAME: begin
				frame_cnt = frame_cnt + 1'b1;
				cur_slot = '0;
				begin_slot(d[IN_RND +: RND_W], r);
			end
			CMD_TICK: begin
				cur_slot = STEP_W'((int'(cur_slot) + 1) % NSLOT);
				begin_slot(d[IN_RND +: RND_W], r);
			end
			CMD_RX: take_header(d, r);
			default: ;
		endcase
		fill_header(r);
		decisions_q.push_back(r);
	endtask

	task automatic check_field(input string name, input logic [63:0] exp_v, input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result %0d field %s: expected %h, actual %h",
					$realtime, n_results, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSLOT; i++) begin
				owner_tbl[i] = FREE_ID;
				heard_tbl[i] = 1'b0;
			end
			frame_cnt = '0;
			cur_slot = '0;
			my_slot = '0;
			my_valid = 1'b0;
			rx_in_slot = 1'b0;
			tx_done = 1'b0;
			listen_cnt = '0;
			node_id = '0;
			decisions_q.delete();
			pending = 0;
			mismatches = 0;
			n_results = 0;
			n_acquired = 0;
			n_acq_failed = 0;
			n_collisions = 0;
			n_tx_slots = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				node_id = cfg_data;

			// compare the outgoing transfer with the oldest expectation
			if (m_tvalid && m_tready) begin
				if (decisions_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result transfer, data %h", $realtime, m_tdata);
				end else begin
					want = decisions_q.pop_front();
					got.txnow  = m_tdata[OUT_TXNOW];
					got.fcnt   = m_tdata[OUT_FCNT +: 16];
					got.ids_lo = m_tdata[OUT_IDS +: 64];
					got.ids_hi = m_tdata[OUT_IDS + 64 +: 16];
					got.oslot  = m_tdata[OUT_OSLOT +: 4];
					got.osv    = m_tdata[OUT_OSV];
					got.coll   = m_tdata[OUT_COLL];
					got.acq    = m_tdata[OUT_ACQ];
					got.fail   = m_tdata[OUT_FAIL];
					check_field("transmit_now", 64'(want.txnow), 64'(got.txnow));
					check_field("tx_frame_count", 64'(want.fcnt), 64'(got.fcnt));
					check_field("tx_ids_low", want.ids_lo, got.ids_lo);
					check_field("tx_ids_high", 64'(want.ids_hi), 64'(got.ids_hi));
					check_field("own_slot", 64'(want.oslot), 64'(got.oslot));
					check_field("own_slot_valid", 64'(want.osv), 64'(got.osv));
					check_field("collision_seen", 64'(want.coll), 64'(got.coll));
					check_field("slot_acquired", 64'(want.acq), 64'(got.acq));
					check_field("acquire_failed", 64'(want.fail), 64'(got.fail));
					n_acquired   += want.acq;
					n_acq_failed += want.fail;
					n_collisions += want.coll;
					n_tx_slots   += want.txnow;
				end
				n_results++;
			end

			if (s_tvalid && s_tready)
				predict_decision(s_tuser, s_tdata);

			pending = decisions_q.size();
		end
	end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the TDMA slot reservation engine
// Drives commands (ticks, frame pulses, good and corrupted headers) under
// several node IDs with random source gaps and sink stalls; the scoreboard
// predicts every decision and the verdict is printed at the end.
// ----------------------------------------------------------------------------
module tb_top;
	import tsr_pkg::*;

	// the command code the block must ignore
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [ID_W-1:0]        cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [CMD_W-1:0]       s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	int pending;
	int mismatches;
	int n_results;
	int n_acquired;
	int n_acq_failed;
	int n_collisions;
	int n_tx_slots;

	// stimulus knobs
	logic [ID_W-1:0] own_id;
	int              free_pct;
	int              hdr_pct;
	bit              tx_gaps;
	bit              rx_stalls;
	int              n_sent;

	tdma_slot_reservation_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	tsr_scoreboard u_scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.pending      (pending),
		.mismatches   (mismatches),
		.n_results    (n_results),
		.n_acquired   (n_acquired),
		.n_acq_failed (n_acq_failed),
		.n_collisions (n_collisions),
		.n_tx_slots   (n_tx_slots)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// generous bound on the whole run
	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// sink side: stall in random bursts while enabled
	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rx_stalls && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	function automatic logic [IN_TDATA_W-1:0] pack_cmd(
		input logic [7:0] len, input logic [7:0] mac, input logic [7:0] fc, input logic mic,
		input logic [8*ID_ENTRIES-1:0] ids, input logic [ID_W-1:0] sender,
		input logic [RND_W-1:0] rnd);
		return {7'b0, rnd, sender, ids, mic, fc, mac, len};
	endfunction

	// slot or sender ID: mostly a small neighborhood, sometimes free or own
	function automatic logic [ID_W-1:0] pick_id(input int free_chance);
		if ($urandom_range(0, 99) < free_chance)
			return FREE_ID;
		case ($urandom_range(0, 7))
			0:       return own_id;
			1, 2, 3, 4, 5: return ID_W'($urandom_range(1, 5));
			default: return ID_W'($urandom);
		endcase
	endfunction

	// Present one transfer and hold it until taken; valid stays high after.
	task automatic send_item(input logic [CMD_W-1:0] c, input logic [IN_TDATA_W-1:0] d);
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
		n_sent++;
	endtask

	// Stop sending and hold off until every decision has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_node_id(input logic [ID_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		own_id = v;
	endtask

	task automatic send_header(input bit good);
		logic [7:0]              len;
		logic [7:0]              mac;
		logic [7:0]              fc;
		logic                    mic;
		logic [8*ID_ENTRIES-1:0] ids;
		len = HDR_LEN;
		mac = MAC_HDR;
		fc  = FRAME_CTRL;
		mic = 1'b1;
		for (int i = 0; i < ID_ENTRIES; i++)
			ids[8*i +: 8] = pick_id(free_pct);
		if (!good) begin
			case ($urandom_range(0, 3))
				0:       len = len ^ 8'($urandom_range(1, 255));
				1:       mac = mac ^ 8'($urandom_range(1, 255));
				2:       fc  = fc ^ 8'($urandom_range(1, 255));
				default: mic = 1'b0;
			endcase
		end
		send_item(CMD_RX, pack_cmd(len, mac, fc, mic, ids, pick_id(5), RND_W'($urandom)));
	endtask

	task automatic send_random();
		int                    r;
		logic [IN_TDATA_W-1:0] noise;
		r = $urandom_range(0, 99);
		noise = {$urandom, $urandom, $urandom, $urandom};
		if (r < hdr_pct)
			send_header(1'b1);
		else if (r < hdr_pct + 8)
			send_header(1'b0);
		else if (r < hdr_pct + 11)
			send_item(CMD_UNUSED, noise);
		else if (r < hdr_pct + 18)
			send_item(CMD_FRAME, noise);
		else
			send_item(CMD_TICK, noise);
	endtask

	task automatic run_phase(input logic [ID_W-1:0] id, input int free_chance,
			input int hdr_chance, input bit gaps, input int count);
		drain_results();
		write_node_id(id);
		free_pct  = free_chance;
		hdr_pct   = hdr_chance;
		tx_gaps   = gaps;
		rx_stalls = gaps;
		repeat (count) send_random();
	endtask

	initial begin
		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= CMD_TICK;
		own_id    = '0;
		free_pct  = 30;
		hdr_pct   = 35;
		tx_gaps   = 1'b1;
		rx_stalls = 1'b1;
		n_sent    = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ignored command, each header check failing, extreme headers
		write_node_id(8'd254);
		send_item(CMD_UNUSED, {$urandom, $urandom, $urandom, $urandom});
		send_item(CMD_RX, pack_cmd(8'd45, MAC_HDR, FRAME_CTRL, 1'b1, '0, 8'd1, '0));
		send_item(CMD_RX, pack_cmd(HDR_LEN, 8'hE1, FRAME_CTRL, 1'b1, '0, 8'd1, '0));
		send_item(CMD_RX, pack_cmd(HDR_LEN, MAC_HDR, 8'h07, 1'b1, '0, 8'd1, '0));
		send_item(CMD_RX, pack_cmd(HDR_LEN, MAC_HDR, FRAME_CTRL, 1'b0, '0, 8'd1, '0));
		send_item(CMD_RX, pack_cmd(HDR_LEN, MAC_HDR, FRAME_CTRL, 1'b1, '0, 8'h00, '0));
		send_item(CMD_RX, pack_cmd(HDR_LEN, MAC_HDR, FRAME_CTRL, 1'b1, '1, 8'hFF, '1));
		// directed: frame pulse, ticks wrapping past the last slot, first acquisition
		send_item(CMD_FRAME, pack_cmd('1, '1, '1, 1'b1, '1, '1, '0));
		repeat (18) send_item(CMD_TICK, '0);
		send_item(CMD_TICK, pack_cmd('0, '0, '0, 1'b0, '0, '0, 16'hFFFF));

		// random: node IDs at both ends and in between, sparse and crowded tables
		run_phase(8'd0, 40, 35, 1'b1, 400);
		run_phase(8'd254, 3, 30, 1'b1, 400);
		run_phase(ID_W'($urandom_range(1, 253)), 60, 40, 1'b1, 400);
		run_phase(ID_W'($urandom_range(1, 253)), 25, 35, 1'b0, 400);

		drain_results();
		repeat (50) @(posedge clk);

		$display("Sent %0d commands, checked %0d decisions across four node IDs.",
			n_sent, n_results);
		$display("Seen: %0d acquisitions, %0d failed acquisitions, %0d collisions, %0d own slots.",
			n_acquired, n_acq_failed, n_collisions, n_tx_slots);
		if (mismatches == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
design/tsr_pkg.sv
design/tdma_slot_reservation_top.sv
design/tsr_checker.sv
test/tsr_checker.sv
test/tb_top.sv
